>>> rtl/core/nns_pkg.sv
// ----------------------------------------------------------------------------
// nns_pkg
// Shared types and constants for the nearest-neighbour image scaler.
// ----------------------------------------------------------------------------
package nns_pkg;

   localparam int SRC_DIM_W   = 11;
   localparam int DST_DIM_W   = 12;
   localparam int SRC_COORD_W = 10;
   localparam int DST_COORD_W = 11;
   localparam int IDX_W       = 21;
   localparam int PIX_W       = 32;
   localparam int SRC_INDEX_W = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [SRC_DIM_W-1:0] SRC_DIM_MAX = 11'd1024;
   localparam logic [DST_DIM_W-1:0] DST_DIM_MAX = 12'd2048;
   localparam logic [PIX_W-1:0]     ALPHA_FORCE = 32'hFF00_0000;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;

   typedef struct packed {
      logic                   mode;
      logic [SRC_INDEX_W-1:0] src_index;
      logic [PIX_W-1:0]       pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]       pixel_out;
      logic [DST_COORD_W-1:0] dest_x;
      logic [DST_COORD_W-1:0] dest_y;
      logic                   frame_end;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ADDR,
      ST_READ,
      ST_EMIT
   } state_type;

endpackage

>>> rtl/core/nns_ram.sv
// ----------------------------------------------------------------------------
// nns_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nns_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/nns_div.sv
// ----------------------------------------------------------------------------
// nns_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nns_div #(
   parameter int DIVIDEND_W = 27,
   parameter int DIVISOR_W  = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (run_ff) begin
         if (!diff[DIVISOR_W]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/nearest_neighbor_image_scaler.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Nearest-neighbour scaler: source pixel store plus raster-order sampler.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: a beat is taken when start is high and busy is low.
//   Mode 0 writes pixel_in to the source store at src_index (indices at or
//   beyond SRC_DEPTH are dropped); busy stays low.
//   Mode 1 samples the next destination pixel in raster order and returns
//   one beat on rsp_data, marked by rsp_valid for a single cycle.
//   A sample runs address multiply, store read and result in turn, and the
//   next command can be taken in the result step. The first sample of a
//   frame also runs both ratio divisions in the shared-start divider pair,
//   one quotient bit per cycle, before the address step.
//   Register port: csr_ready is always high; write only while quiet.
//   Reset clears the frame counters and accumulators and sets all four
//   dimension registers to 256. The store is not cleared; unwritten
//   entries read back undefined. The receiver cannot stall rsp beats.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler #(
   parameter int SRC_DEPTH = 65536,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  nns_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output nns_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nns_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nns_pkg::CSR_DATA_W-1:0]   csr_data
);

   import nns_pkg::*;

   localparam int ADDR_W  = $clog2(SRC_DEPTH);
   localparam int RATIO_W = SRC_DIM_W + FRAC_BITS;
   localparam int ACC_W   = RATIO_W + DST_COORD_W;
   localparam int SXR_W   = ACC_W - FRAC_BITS;

   function automatic logic [SRC_DIM_W-1:0] sat_src(input logic [SRC_DIM_W-1:0] v);
      if (v == '0) begin
         return SRC_DIM_W'(1);
      end else if (v > SRC_DIM_MAX) begin
         return SRC_DIM_MAX;
      end else begin
         return v;
      end
   endfunction

   function automatic logic [DST_DIM_W-1:0] sat_dst(input logic [DST_DIM_W-1:0] v);
      if (v == '0) begin
         return DST_DIM_W'(1);
      end else if (v > DST_DIM_MAX) begin
         return DST_DIM_MAX;
      end else begin
         return v;
      end
   endfunction

   state_type                state_ff, state_in;

   logic [SRC_DIM_W-1:0]     src_width_ff, src_height_ff;
   logic [DST_DIM_W-1:0]     dst_width_ff, dst_height_ff;

   logic [DST_COORD_W-1:0]   dest_col_ff, dest_col_in;
   logic [DST_COORD_W-1:0]   dest_row_ff, dest_row_in;
   logic [ACC_W-1:0]         col_accum_ff, col_accum_in;
   logic [ACC_W-1:0]         row_accum_ff, row_accum_in;
   logic [RATIO_W-1:0]       col_ratio_ff, col_ratio_in;
   logic [RATIO_W-1:0]       row_ratio_ff, row_ratio_in;

   logic [SRC_COORD_W-1:0]   sx_ff, sx_in;
   logic [IDX_W-1:0]         prod_ff, prod_in;
   logic                     oob_ff, oob_in;
   logic [DST_COORD_W-1:0]   dest_x_ff, dest_x_in;
   logic [DST_COORD_W-1:0]   dest_y_ff, dest_y_in;
   logic                     frame_end_ff, frame_end_in;

   logic [SRC_DIM_W-1:0]     sw, sh;
   logic [DST_DIM_W-1:0]     dw, dh;
   logic [SXR_W-1:0]         sx_raw, sy_raw;
   logic [SRC_COORD_W-1:0]   sx_clamp, sy_clamp;
   logic [IDX_W-1:0]         prod;
   logic [IDX_W-1:0]         rd_idx;
   logic                     rd_oob;
   logic [IDX_W-1:0]         wr_idx;
   logic                     row_end, frame_end;

   logic                     accept, sample, frame_start;
   logic                     div_start;
   logic                     col_done, row_done;
   logic [RATIO_W-1:0]       col_quo, row_quo;
   logic                     ram_we, ram_re;
   logic [PIX_W-1:0]         ram_rdata;

   assign accept      = start && !busy;
   assign sample      = req_data.mode == MODE_SAMPLE;
   assign frame_start = (dest_col_ff == '0) && (dest_row_ff == '0);
   assign csr_ready   = 1'b1;

   assign sw = sat_src(src_width_ff);
   assign sh = sat_src(src_height_ff);
   assign dw = sat_dst(dst_width_ff);
   assign dh = sat_dst(dst_height_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_DIM_W'(256);
         src_height_ff <= SRC_DIM_W'(256);
         dst_width_ff  <= DST_DIM_W'(256);
         dst_height_ff <= DST_DIM_W'(256);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_data[SRC_DIM_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_data[SRC_DIM_W-1:0];
            CSR_DST_WIDTH:  dst_width_ff  <= csr_data[DST_DIM_W-1:0];
            CSR_DST_HEIGHT: dst_height_ff <= csr_data[DST_DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // ratio dividers, started together at frame start
   nns_div #(
      .DIVIDEND_W (RATIO_W),
      .DIVISOR_W  (DST_DIM_W)
   ) u_col_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sw, FRAC_BITS'(0)}),
      .divisor  (dw),
      .done     (col_done),
      .quotient (col_quo)
   );

   nns_div #(
      .DIVIDEND_W (RATIO_W),
      .DIVISOR_W  (DST_DIM_W)
   ) u_row_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sh, FRAC_BITS'(0)}),
      .divisor  (dh),
      .done     (row_done),
      .quotient (row_quo)
   );

   // source store
   assign wr_idx = IDX_W'(req_data.src_index);
   assign ram_we = accept && !sample && (wr_idx < IDX_W'(SRC_DEPTH));

   nns_ram #(
      .DATA_W (PIX_W),
      .DEPTH  (SRC_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_idx[ADDR_W-1:0]),
      .wdata (req_data.pixel_in),
      .re    (ram_re),
      .raddr (rd_idx[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   // sampling arithmetic
   assign sx_raw   = col_accum_ff[ACC_W-1:FRAC_BITS];
   assign sy_raw   = row_accum_ff[ACC_W-1:FRAC_BITS];
   assign sx_clamp = (sx_raw >= SXR_W'(sw)) ? SRC_COORD_W'(sw - SRC_DIM_W'(1))
                                            : sx_raw[SRC_COORD_W-1:0];
   assign sy_clamp = (sy_raw >= SXR_W'(sh)) ? SRC_COORD_W'(sh - SRC_DIM_W'(1))
                                            : sy_raw[SRC_COORD_W-1:0];
   assign prod     = IDX_W'(sy_clamp) * IDX_W'(sw);
   assign rd_idx   = prod_ff + IDX_W'(sx_ff);
   assign rd_oob   = rd_idx >= IDX_W'(SRC_DEPTH);

   assign row_end   = (DST_DIM_W'(dest_col_ff) + DST_DIM_W'(1)) >= dw;
   assign frame_end = row_end && ((DST_DIM_W'(dest_row_ff) + DST_DIM_W'(1)) >= dh);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE, ST_EMIT: begin
            if (accept && sample) begin
               state_in = frame_start ? ST_DIV : ST_ADDR;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (col_done) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: state_in = ST_READ;
         ST_READ: state_in = ST_EMIT;
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      busy      = 1'b0;
      rsp_valid = 1'b0;
      ram_re    = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_DIV, ST_ADDR: busy = 1'b1;
         ST_READ: begin
            busy   = 1'b1;
            ram_re = !rd_oob;
         end
         ST_EMIT: rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   assign div_start = accept && sample && frame_start;

   // datapath next values
   always_comb begin
      dest_col_in  = dest_col_ff;
      dest_row_in  = dest_row_ff;
      col_accum_in = col_accum_ff;
      row_accum_in = row_accum_ff;
      col_ratio_in = col_ratio_ff;
      row_ratio_in = row_ratio_ff;
      sx_in        = sx_ff;
      prod_in      = prod_ff;
      oob_in       = oob_ff;
      dest_x_in    = dest_x_ff;
      dest_y_in    = dest_y_ff;
      frame_end_in = frame_end_ff;
      if (state_ff == ST_DIV && col_done) begin
         col_ratio_in = col_quo;
         row_ratio_in = row_quo;
         col_accum_in = '0;
         row_accum_in = '0;
      end
      if (state_ff == ST_ADDR) begin
         sx_in        = sx_clamp;
         prod_in      = prod;
         dest_x_in    = dest_col_ff;
         dest_y_in    = dest_row_ff;
         frame_end_in = frame_end;
         if (frame_end) begin
            dest_col_in  = '0;
            dest_row_in  = '0;
            col_accum_in = '0;
            row_accum_in = '0;
         end else if (row_end) begin
            dest_col_in  = '0;
            col_accum_in = '0;
            dest_row_in  = dest_row_ff + DST_COORD_W'(1);
            row_accum_in = row_accum_ff + ACC_W'(row_ratio_ff);
         end else begin
            dest_col_in  = dest_col_ff + DST_COORD_W'(1);
            col_accum_in = col_accum_ff + ACC_W'(col_ratio_ff);
         end
      end
      if (state_ff == ST_READ) begin
         oob_in = rd_oob;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dest_col_ff  <= '0;
         dest_row_ff  <= '0;
         col_accum_ff <= '0;
         row_accum_ff <= '0;
      end else begin
         state_ff     <= state_in;
         dest_col_ff  <= dest_col_in;
         dest_row_ff  <= dest_row_in;
         col_accum_ff <= col_accum_in;
         row_accum_ff <= row_accum_in;
      end
      col_ratio_ff <= col_ratio_in;
      row_ratio_ff <= row_ratio_in;
      sx_ff        <= sx_in;
      prod_ff      <= prod_in;
      oob_ff       <= oob_in;
      dest_x_ff    <= dest_x_in;
      dest_y_ff    <= dest_y_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_data.pixel_out = oob_ff ? ALPHA_FORCE : (ram_rdata | ALPHA_FORCE);
   assign rsp_data.dest_x    = dest_x_ff;
   assign rsp_data.dest_y    = dest_y_ff;
   assign rsp_data.frame_end = frame_end_ff;

   // checks
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      col_done == row_done)
      else $error("ratio dividers out of step");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat repeated");

   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_WRITE) |=> !busy)
      else $error("store write stalled the command channel");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_end) |-> (dest_col_ff == '0 && dest_row_ff == '0))
      else $error("counters not wrapped at frame end");

endmodule
